[src/adsr_pkg.sv]
// shared types, constants and codes of the adsr envelope generator
package adsr_pkg;

    localparam int LVL_FRAC    = 23;
    localparam int LVL_W       = LVL_FRAC + 1;
    localparam int SAMPLE_W    = 24;
    localparam int CFG_LEN_W   = 21;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int COUNT_BITS_DEF = 21;
    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1) << LVL_FRAC;

    typedef enum logic [2:0] {
        STAGE_IDLE    = 3'd0,
        STAGE_ATTACK  = 3'd1,
        STAGE_DECAY   = 3'd2,
        STAGE_SUSTAIN = 3'd3,
        STAGE_RELEASE = 3'd4
    } stage_t;

    typedef enum logic [2:0] {
        CFG_ATTACK  = 3'd0,
        CFG_DECAY   = 3'd1,
        CFG_SUSTAIN = 3'd2,
        CFG_RELEASE = 3'd3,
        CFG_CURVE   = 3'd4,
        CFG_FLOOR   = 3'd5,
        CFG_BYPASS  = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        SEQ_READY,
        SEQ_EVENT,
        SEQ_DIV_EVT,
        SEQ_STEP,
        SEQ_DIV_DEC,
        SEQ_SQUARE,
        SEQ_SCALE,
        SEQ_FIN
    } seq_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_sample;
        logic                       note_on;
        logic                       retrigger;
        logic                       note_off;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic [LVL_W-1:0]           envelope_level;
        logic [2:0]                 stage_now;
    } result_t;

endpackage

[src/adsr_divider.sv]
// restoring divider, one quotient bit per cycle
module adsr_divider #(
    parameter int DVD_BITS = adsr_pkg::LVL_W,
    parameter int DVS_BITS = adsr_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_BITS-1:0] dividend,
    input  logic [DVS_BITS-1:0] divisor,
    output logic                done,
    output logic [DVD_BITS-1:0] quotient
);

    localparam int CNT_W = (DVD_BITS > 1) ? $clog2(DVD_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_BITS - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DVD_BITS-1:0] dq_reg, dq_next;
    logic [DVS_BITS-1:0] rem_reg, rem_next;
    logic [DVS_BITS-1:0] dvs_reg, dvs_next;
    logic [DVS_BITS:0]   rem_shift;
    logic                ge;

    assign rem_shift = {rem_reg, dq_reg[DVD_BITS-1]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[DVD_BITS-2:0], ge};
            rem_next = ge ? DVS_BITS'(rem_shift - {1'b0, dvs_reg}) : DVS_BITS'(rem_shift);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

[src/adsr_envelope_generator.sv]
// adsr envelope generator top level: sequencer, envelope state, shared multiplier
//
// one sample beat in on item, one result beat out on result; both channels use
// valid/stall and a beat moves when valid is high and stall is low.
// item_stall is low only while the sequencer is ready; after a beat is taken it
// stays high until that beat's result has been loaded into the output register.
// an accepted beat passes the event, step, square and scale steps on its way to
// the result; a note event and an attack end each start a stage, and each stage
// start adds one pass of the 24-step restoring divider and waits for its done
// pulse. bypass beats go straight to the result. the next beat is taken the
// cycle after the result is loaded.
// one shared 25x25 multiplier forms the squared level and then the scaled sample.
// the result register holds a beat while result_stall is high; the next item is
// accepted as soon as the current result is loaded, even if it is still waiting.
// configuration writes on cfg_we/cfg_index/cfg_data go straight into the
// registers and are meant to happen between items.
// reset clears the envelope to idle at level zero and loads the default settings.
module adsr_envelope_generator #(
    parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  adsr_pkg::item_t                    item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output adsr_pkg::result_t                  result,
    input  logic                               cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LW  = adsr_pkg::LVL_W;
    localparam int LF  = adsr_pkg::LVL_FRAC;
    localparam int CLW = adsr_pkg::CFG_LEN_W;
    localparam int SW  = adsr_pkg::SAMPLE_W;
    localparam logic [LW-1:0] ONE = adsr_pkg::LVL_ONE;

    // settings
    logic [CLW-1:0] attack_reg, decay_reg, release_reg;
    logic [LW-1:0]  sustain_reg, floor_reg;
    logic           curve_reg, bypass_reg;

    // sequencer and envelope state
    adsr_pkg::seq_t    seq_reg, seq_next;
    adsr_pkg::stage_t  stage_reg, stage_next;
    adsr_pkg::item_t   item_reg, item_next;
    adsr_pkg::result_t result_reg, result_next;
    logic                   result_valid_reg, result_valid_next;
    logic [LW-1:0]          level_reg, level_next;
    logic signed [LW:0]     inc_reg, inc_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [COUNT_BITS-1:0]  len_reg, len_next;
    logic                   neg_reg, neg_next;
    logic [LW-1:0]          env_reg, env_next;
    logic [SW-1:0]          y_reg, y_next;

    // working signals
    logic [LW-1:0]          sus_sat;
    logic [COUNT_BITS-1:0]  att_len, dec_len, rel_len;
    logic                   on_go, off_go;
    adsr_pkg::stage_t       stage_on;
    logic [LW-1:0]          set_tgt, set_lvl;
    logic signed [LW:0]     set_diff;
    logic [LW-1:0]          set_mag;
    logic                   div_start, div_done;
    logic [LW-1:0]          div_quo;
    logic [COUNT_BITS-1:0]  count_inc;
    logic                   complete;
    logic signed [LW+1:0]   lvl_sum;
    logic signed [LW:0]     mul_a, mul_b;
    logic signed [2*LW+1:0] mul_p;

    function automatic logic [COUNT_BITS-1:0] eff_len(input logic [CLW-1:0] r);
        logic [COUNT_BITS-1:0] l;
        l = COUNT_BITS'(r);
        return (l == '0) ? COUNT_BITS'(1) : l;
    endfunction

    function automatic logic [LW-1:0] clamp_lvl(input logic signed [LW+1:0] v,
                                                 input logic [LW-1:0] lo);
        logic [LW-1:0] r;
        if (v < $signed({2'b00, lo}))
            r = lo;
        else if (v > $signed({2'b00, ONE}))
            r = ONE;
        else
            r = v[LW-1:0];
        return r;
    endfunction

    assign sus_sat = (sustain_reg > ONE) ? ONE : sustain_reg;
    assign att_len = eff_len(attack_reg);
    assign dec_len = eff_len(decay_reg);
    assign rel_len = eff_len(release_reg);

    assign on_go    = item_reg.note_on
                   && (item_reg.retrigger || stage_reg == adsr_pkg::STAGE_IDLE);
    assign stage_on = on_go ? adsr_pkg::STAGE_ATTACK : stage_reg;
    assign off_go   = item_reg.note_off && stage_on != adsr_pkg::STAGE_IDLE
                   && stage_on != adsr_pkg::STAGE_RELEASE;

    assign count_inc = (len_reg != '0) ? count_reg + 1'b1 : count_reg;
    assign complete  = (len_reg != '0) && (count_inc >= len_reg);
    assign lvl_sum   = $signed({2'b00, level_reg}) + $signed({inc_reg[LW], inc_reg});

    assign set_diff = $signed({1'b0, set_tgt}) - $signed({1'b0, set_lvl});
    assign set_mag  = set_diff[LW] ? LW'(-set_diff) : set_diff[LW-1:0];

    assign mul_p = mul_a * mul_b;

    adsr_divider #(
        .DVD_BITS (LW),
        .DVS_BITS (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (set_mag),
        .divisor  (len_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        seq_next          = seq_reg;
        stage_next        = stage_reg;
        item_next         = item_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        level_next        = level_reg;
        inc_next          = inc_reg;
        count_next        = count_reg;
        len_next          = len_reg;
        neg_next          = neg_reg;
        env_next          = env_reg;
        y_next            = y_reg;
        set_tgt           = ONE;
        set_lvl           = level_reg;
        div_start         = 1'b0;
        mul_a             = $signed({1'b0, level_reg});
        mul_b             = $signed({1'b0, level_reg});

        unique case (seq_reg)
            adsr_pkg::SEQ_READY:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    if (bypass_reg)
                    begin
                        y_next   = item.in_sample;
                        env_next = ONE;
                        seq_next = adsr_pkg::SEQ_FIN;
                    end
                    else
                        seq_next = adsr_pkg::SEQ_EVENT;
                end
            end
            adsr_pkg::SEQ_EVENT:
            begin
                if (off_go || on_go)
                begin
                    set_tgt    = off_go ? '0 : ONE;
                    len_next   = off_go ? rel_len : att_len;
                    stage_next = off_go ? adsr_pkg::STAGE_RELEASE : adsr_pkg::STAGE_ATTACK;
                    count_next = '0;
                    neg_next   = set_diff[LW];
                    div_start  = 1'b1;
                    seq_next   = adsr_pkg::SEQ_DIV_EVT;
                end
                else
                    seq_next = adsr_pkg::SEQ_STEP;
            end
            adsr_pkg::SEQ_DIV_EVT, adsr_pkg::SEQ_DIV_DEC:
            begin
                if (div_done)
                begin
                    inc_next = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
                    seq_next = (seq_reg == adsr_pkg::SEQ_DIV_EVT) ? adsr_pkg::SEQ_STEP
                                                                 : adsr_pkg::SEQ_SQUARE;
                end
            end
            adsr_pkg::SEQ_STEP:
            begin
                count_next = count_inc;
                seq_next   = adsr_pkg::SEQ_SQUARE;
                unique case (stage_reg)
                    adsr_pkg::STAGE_ATTACK:
                    begin
                        if (complete)
                        begin
                            level_next = ONE;
                            set_lvl    = ONE;
                            set_tgt    = sus_sat;
                            len_next   = dec_len;
                            stage_next = adsr_pkg::STAGE_DECAY;
                            count_next = '0;
                            neg_next   = set_diff[LW];
                            div_start  = 1'b1;
                            seq_next   = adsr_pkg::SEQ_DIV_DEC;
                        end
                        else
                            level_next = clamp_lvl(lvl_sum, '0);
                    end
                    adsr_pkg::STAGE_DECAY:
                    begin
                        if (complete)
                        begin
                            level_next = sus_sat;
                            stage_next = adsr_pkg::STAGE_SUSTAIN;
                            count_next = '0;
                            len_next   = '0;
                            inc_next   = '0;
                        end
                        else
                            level_next = clamp_lvl(lvl_sum, sus_sat);
                    end
                    adsr_pkg::STAGE_SUSTAIN:
                        level_next = sus_sat;
                    adsr_pkg::STAGE_RELEASE:
                    begin
                        if (complete)
                        begin
                            level_next = '0;
                            stage_next = adsr_pkg::STAGE_IDLE;
                            count_next = '0;
                            len_next   = '0;
                            inc_next   = '0;
                        end
                        else
                            level_next = clamp_lvl(lvl_sum, '0);
                    end
                    default:
                        level_next = '0;
                endcase
            end
            adsr_pkg::SEQ_SQUARE:
            begin
                if (!curve_reg)
                    env_next = level_reg;
                else if (level_reg <= floor_reg)
                    env_next = '0;
                else
                    env_next = mul_p[LF+LW-1:LF];
                seq_next = adsr_pkg::SEQ_SCALE;
            end
            adsr_pkg::SEQ_SCALE:
            begin
                mul_a    = $signed({item_reg.in_sample[SW-1], item_reg.in_sample});
                mul_b    = $signed({1'b0, env_reg});
                y_next   = mul_p[LF+SW-1:LF];
                seq_next = adsr_pkg::SEQ_FIN;
            end
            adsr_pkg::SEQ_FIN:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.out_sample     = y_reg;
                    result_next.envelope_level = env_reg;
                    result_next.stage_now      = stage_reg;
                    result_valid_next          = 1'b1;
                    seq_next                   = adsr_pkg::SEQ_READY;
                end
            end
            default:
                seq_next = adsr_pkg::SEQ_READY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg          <= adsr_pkg::SEQ_READY;
            stage_reg        <= adsr_pkg::STAGE_IDLE;
            result_valid_reg <= 1'b0;
            level_reg        <= '0;
            inc_reg          <= '0;
            count_reg        <= '0;
            len_reg          <= '0;
            neg_reg          <= 1'b0;
        end
        else
        begin
            seq_reg          <= seq_next;
            stage_reg        <= stage_next;
            result_valid_reg <= result_valid_next;
            level_reg        <= level_next;
            inc_reg          <= inc_next;
            count_reg        <= count_next;
            len_reg          <= len_next;
            neg_reg          <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
        env_reg    <= env_next;
        y_reg      <= y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= CLW'(480);
            decay_reg   <= CLW'(4800);
            sustain_reg <= LW'(5872026);
            release_reg <= CLW'(14400);
            curve_reg   <= 1'b0;
            floor_reg   <= '0;
            bypass_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (adsr_pkg::cfg_idx_t'(cfg_index))
                adsr_pkg::CFG_ATTACK:  attack_reg  <= cfg_data[CLW-1:0];
                adsr_pkg::CFG_DECAY:   decay_reg   <= cfg_data[CLW-1:0];
                adsr_pkg::CFG_SUSTAIN: sustain_reg <= cfg_data[LW-1:0];
                adsr_pkg::CFG_RELEASE: release_reg <= cfg_data[CLW-1:0];
                adsr_pkg::CFG_CURVE:   curve_reg   <= cfg_data[0];
                adsr_pkg::CFG_FLOOR:   floor_reg   <= cfg_data[LW-1:0];
                adsr_pkg::CFG_BYPASS:  bypass_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign item_stall   = seq_reg != adsr_pkg::SEQ_READY;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("sequencer ready right after taking a beat");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= ONE)
        else $error("envelope level above full scale");

    a_untimed_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == adsr_pkg::SEQ_READY
        && (stage_reg == adsr_pkg::STAGE_IDLE || stage_reg == adsr_pkg::STAGE_SUSTAIN)
        |-> len_reg == '0)
        else $error("untimed stage holds a length");

    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == adsr_pkg::SEQ_READY && len_reg != '0 |-> count_reg < len_reg)
        else $error("stage counter reached its length between beats");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> seq_reg == adsr_pkg::SEQ_DIV_EVT || seq_reg == adsr_pkg::SEQ_DIV_DEC)
        else $error("divider finished outside a divide step");

endmodule
